// ===== design/u2u_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; used by u2u_decode, u2u_emit and utf8_to_utf16_transcoder.
package u2u_pkg;

  // Default width of the running unit counter
  localparam int unsigned COUNT_BITS_DEFAULT = 16;

  // Most code units that one input byte can cause (surrogate pair + terminator)
  localparam int unsigned MAX_UNITS = 3;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned CP_W    = 21;

  // Surrogate construction
  localparam logic [25:0]       SUPP_OFFSET = 26'h001_0000;
  localparam logic [UNIT_W-1:0] HI_SURR     = 16'hD800;
  localparam logic [UNIT_W-1:0] LO_SURR     = 16'hDC00;
  localparam logic [UNIT_W-1:0] TERM_UNIT   = 16'h0000;

  // One result: code unit with its flags and the running count
  typedef struct packed {
    logic [UNIT_W-1:0] code;
    logic              run_last;
    logic              string_end;
    logic [UNIT_W-1:0] total;
  } unit_t;

  // All results caused by one byte, slot 0 first
  typedef struct packed {
    unit_t [MAX_UNITS-1:0] units;
    logic  [1:0]           n;
  } bundle_t;

endpackage

// ===== design/u2u_decode.sv =====
// Byte decoder: sequence state, unit counter, terminator flag and unit build.
// Depends on u2u_pkg; hands a bundle of up to three units to u2u_emit.
module u2u_decode #(
  parameter int unsigned COUNT_BITS = u2u_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         accept_i,
  input  logic [u2u_pkg::BYTE_W-1:0]   byte_i,
  input  logic                         last_i,
  output logic                         load_o,
  output u2u_pkg::bundle_t             bundle_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic                        term_q;
  logic [u2u_pkg::CP_W-1:0]    pcp_q, pcp_d;
  logic [1:0]                  rem_q, rem_d;
  logic                        four_q, four_d;
  logic [COUNT_BITS-1:0]       cnt_q, cnt_d;

  logic [u2u_pkg::CP_W-1:0]    pcp_shift;
  logic [25:0]                 cp_off;
  u2u_pkg::bundle_t            bundle;

  // Saturating increment of the counter
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS-1:0] r;
    r = (c == CNT_MAX) ? c : c + 1'b1;
    return r;
  endfunction

  // Counter as shown on the port: low 16 bits, zero-extended when narrower
  function automatic logic [u2u_pkg::UNIT_W-1:0] count_view(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS+u2u_pkg::UNIT_W-1:0] e;
    e = {{u2u_pkg::UNIT_W{1'b0}}, c};
    return e[u2u_pkg::UNIT_W-1:0];
  endfunction

  // Continuation byte adds its low six bits
  assign pcp_shift = {pcp_q[u2u_pkg::CP_W-7:0], byte_i[5:0]};
  assign cp_off    = {5'b0, pcp_shift} - u2u_pkg::SUPP_OFFSET;

  // Decode one byte into its units and next state
  always_comb begin
    logic [COUNT_BITS-1:0] cnt_v;
    logic [1:0]            n_v;
    bundle = '0;
    pcp_d  = pcp_q;
    rem_d  = rem_q;
    four_d = four_q;
    cnt_v  = cnt_q;
    n_v    = 2'd0;

    if (rem_q == 2'd0) begin
      if (!byte_i[7]) begin
        cnt_v                    = sat_inc(cnt_v);
        bundle.units[n_v].code  = {8'b0, byte_i};
        bundle.units[n_v].total = count_view(cnt_v);
        n_v                      = n_v + 2'd1;
      end else if (byte_i[7:5] == 3'b110) begin
        pcp_d  = {16'b0, byte_i[4:0]};
        rem_d  = 2'd1;
        four_d = 1'b0;
      end else if (byte_i[7:4] == 4'b1110) begin
        pcp_d  = {17'b0, byte_i[3:0]};
        rem_d  = 2'd2;
        four_d = 1'b0;
      end else begin
        // stray continuation and 0xF0..0xFF all open a four-byte sequence
        pcp_d  = {18'b0, byte_i[2:0]};
        rem_d  = 2'd3;
        four_d = 1'b1;
      end
    end else begin
      pcp_d = pcp_shift;
      rem_d = rem_q - 2'd1;
      if (rem_q == 2'd1) begin
        if (four_q) begin
          cnt_v                    = sat_inc(cnt_v);
          bundle.units[n_v].code  = u2u_pkg::HI_SURR + cp_off[25:10];
          bundle.units[n_v].total = count_view(cnt_v);
          n_v                      = n_v + 2'd1;
          cnt_v                    = sat_inc(cnt_v);
          bundle.units[n_v].code  = u2u_pkg::LO_SURR + {6'b0, cp_off[9:0]};
          bundle.units[n_v].total = count_view(cnt_v);
          n_v                      = n_v + 2'd1;
        end else begin
          cnt_v                    = sat_inc(cnt_v);
          bundle.units[n_v].code  = pcp_shift[u2u_pkg::UNIT_W-1:0];
          bundle.units[n_v].total = count_view(cnt_v);
          n_v                      = n_v + 2'd1;
        end
        pcp_d  = '0;
        four_d = 1'b0;
      end
    end

    // end of string: optional terminator, then back to reset state
    if (last_i) begin
      if (term_q) begin
        bundle.units[n_v].code  = u2u_pkg::TERM_UNIT;
        bundle.units[n_v].total = count_view(cnt_v);
        n_v                      = n_v + 2'd1;
      end
      if (n_v != 2'd0) begin
        bundle.units[n_v - 2'd1].string_end = 1'b1;
      end
      pcp_d  = '0;
      rem_d  = 2'd0;
      four_d = 1'b0;
      cnt_v  = '0;
    end

    if (n_v != 2'd0) begin
      bundle.units[n_v - 2'd1].run_last = 1'b1;
    end
    bundle.n = n_v;
    cnt_d    = cnt_v;
  end

  // Configuration flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= 1'b0;
    end else if (cfg_we_i) begin
      term_q <= cfg_wdata_i;
    end
  end

  // Sequence state and counter advance on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcp_q  <= '0;
      rem_q  <= 2'd0;
      four_q <= 1'b0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      pcp_q  <= pcp_d;
      rem_q  <= rem_d;
      four_q <= four_d;
      cnt_q  <= cnt_d;
    end
  end

  assign load_o   = accept_i && (bundle.n != 2'd0);
  assign bundle_o = bundle;

endmodule

// ===== design/u2u_emit.sv =====
// Result register: holds one byte's units and hands them out one per cycle while m_axis_tready is high.
// Depends on u2u_pkg; fed by u2u_decode.
module u2u_emit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  u2u_pkg::bundle_t                bundle_i,
  output logic                            ready_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [2*u2u_pkg::UNIT_W-1:0]    m_axis_tdata,
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);

  u2u_pkg::unit_t [u2u_pkg::MAX_UNITS-1:0] units_q;
  logic [1:0]                               n_q;
  logic                                     valid_q;
  logic                                     take;
  logic                                     last_take;

  assign take      = valid_q && m_axis_tready;
  assign last_take = take && (n_q == 2'd1);
  // a new bundle may enter as the final unit of the old one leaves
  assign ready_o   = !valid_q || last_take;

  // Control: valid flag and units left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      n_q     <= 2'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      n_q     <= bundle_i.n;
    end else if (take) begin
      valid_q <= (n_q != 2'd1);
      n_q     <= n_q - 2'd1;
    end
  end

  // Payload: load or shift down by one slot
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      units_q <= bundle_i.units;
    end else if (take) begin
      units_q <= {u2u_pkg::unit_t'('0), units_q[u2u_pkg::MAX_UNITS-1:1]};
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {units_q[0].total, units_q[0].code};
  assign m_axis_tuser  = units_q[0].run_last;
  assign m_axis_tlast  = units_q[0].string_end;

  // A bundle is only loaded when the register is free or draining its last unit
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ready_o)
    else $error("bundle loaded over pending units");

  // The byte's last unit is the one shown when a single unit remains
  a_run_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (units_q[0].run_last == (n_q == 2'd1)))
    else $error("run_last out of place");

  // Taking a unit that is not the last keeps the register full
  a_keep_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (n_q != 2'd1)) |=> valid_q)
    else $error("units lost after a take");

  // A full register never counts zero units
  a_count_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (n_q != 2'd0))
    else $error("valid with no units");

endmodule

// ===== design/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder: stream ports and config write.
// Depends on u2u_pkg, u2u_decode and u2u_emit.
//
//  channel  | direction | request moved                    | handshake
//  ---------+-----------+----------------------------------+----------------
//  s_axis   | in        | one UTF-8 byte, tlast = last one | tvalid & tready
//  m_axis   | out       | one UTF-16 unit with count/flags | tvalid & tready
//  cfg      | in        | append_terminator flag           | cfg_we_i
//
//  A byte is decoded in the cycle it is accepted and its units land in the
//  result register; bytes that yield at most one unit go at one per cycle
//  while m_axis_tready is high. A byte that yields more units (surrogate pair,
//  terminator) keeps s_axis_tready low until its final unit is being taken.
//  Reset clears sequence state, counter, flag and the result register's valid flag and count; no sweep.
//  Downstream stalls back up to s_axis_tready with no request lost.
module utf8_to_utf16_transcoder #(
  parameter int unsigned COUNT_BITS = u2u_pkg::COUNT_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // append_terminator
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] code_unit, [31:16] units_total
  output logic        m_axis_tuser,   // run_last
  output logic        m_axis_tlast    // string_end
);

  logic             accept;
  logic             load;
  logic             emit_ready;
  u2u_pkg::bundle_t bundle;

  assign s_axis_tready = emit_ready;
  assign accept        = s_axis_tvalid && emit_ready;

  u2u_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .load_o      (load),
    .bundle_o    (bundle)
  );

  u2u_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .bundle_i      (bundle),
    .ready_o       (emit_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for utf8_to_utf16_transcoder: streams UTF-8 bytes with random
// gaps and stalls and checks every UTF-16 unit against a built-in decoder model.
// Depends on u2u_pkg and the transcoder RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One byte waiting to be offered, with its lead-in gap in cycles
  typedef struct {
    logic [7:0] data;
    logic       fin;
    int         gap;
  } byte_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;     // [7:0] in_byte
  logic        s_axis_tlast = 1'b0;   // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // [15:0] code_unit, [31:16] units_total
  logic        m_axis_tuser;          // run_last
  logic        m_axis_tlast;          // string_end

  // Stimulus and expectation stores
  byte_req_t        byte_reqs[$];
  u2u_pkg::unit_t   units_due[$];
  byte_req_t        tx_req;
  int               tx_wait = 0;
  int               tx_calm = 0;
  int               bytes_taken = 0;

  // Receiver control
  int               rx_wait = 0;
  int               rx_calm = 0;
  int               rx_stall;
  logic             hold_off = 1'b0;
  int               fail_count = 0;
  u2u_pkg::unit_t   want;

  // Decoder model state
  logic             term_on = 1'b0;
  logic [20:0]      cp_acc = '0;
  logic [1:0]       seq_left = '0;
  logic             seq_pair = 1'b0;
  logic [15:0]      unit_count = '0;
  u2u_pkg::unit_t   step_buf[3];
  int               step_n;

  utf8_to_utf16_transcoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Idle length for one request; now and then a run of back-to-back requests
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // Append one unit to this byte's batch, bumping the saturating count
  task automatic add_unit(input logic [15:0] code, input logic counted);
    if (counted && unit_count != 16'hFFFF) unit_count++;
    step_buf[step_n].code       = code;
    step_buf[step_n].run_last   = 1'b0;
    step_buf[step_n].string_end = 1'b0;
    step_buf[step_n].total      = unit_count;
    step_n++;
  endtask

  // Decode one accepted byte and queue the units it should produce
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [31:0] cp;
    step_n = 0;
    if (seq_left == 2'd0) begin
      if (b < 8'h80) begin
        add_unit({8'h00, b}, 1'b1);
      end else if ((b & 8'hE0) == 8'hC0) begin
        cp_acc   = {16'h0, b[4:0]};
        seq_left = 2'd1;
        seq_pair = 1'b0;
      end else if ((b & 8'hF0) == 8'hE0) begin
        cp_acc   = {17'h0, b[3:0]};
        seq_left = 2'd2;
        seq_pair = 1'b0;
      end else begin
        // everything else, stray continuations included, opens four bytes
        cp_acc   = {18'h0, b[2:0]};
        seq_left = 2'd3;
        seq_pair = 1'b1;
      end
    end else begin
      cp_acc = {cp_acc[14:0], b[5:0]};
      seq_left--;
      if (seq_left == 2'd0) begin
        if (seq_pair) begin
          // wraps for values below 0x10000; halves truncated to 16 bits
          cp = {11'h0, cp_acc} - 32'h0001_0000;
          add_unit(u2u_pkg::HI_SURR + cp[25:10], 1'b1);
          add_unit(u2u_pkg::LO_SURR + {6'h0, cp[9:0]}, 1'b1);
        end else begin
          add_unit(cp_acc[15:0], 1'b1);
        end
        cp_acc   = '0;
        seq_pair = 1'b0;
      end
    end
    // end of string: optional terminator, then back to the idle state
    if (fin) begin
      if (term_on) add_unit(u2u_pkg::TERM_UNIT, 1'b0);
      if (step_n > 0) step_buf[step_n-1].string_end = 1'b1;
      cp_acc     = '0;
      seq_left   = '0;
      seq_pair   = 1'b0;
      unit_count = '0;
    end
    if (step_n > 0) step_buf[step_n-1].run_last = 1'b1;
    for (int k = 0; k < step_n; k++) units_due.push_back(step_buf[k]);
  endtask

  // Sender: offers queued bytes, each after its own gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      tx_wait       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tlast);
        bytes_taken <= bytes_taken + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (byte_reqs.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (tx_wait < byte_reqs[0].gap) begin
          tx_wait       <= tx_wait + 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          tx_req = byte_reqs.pop_front();
          s_axis_tdata  <= tx_req.data;
          s_axis_tlast  <= tx_req.fin;
          s_axis_tvalid <= 1'b1;
          tx_wait       <= 0;
        end
      end
    end
  end

  // Receiver: checks each accepted unit against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (units_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected unit: code %h total %h run_last %b string_end %b",
                     m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser, m_axis_tlast);
          fail_count++;
        end else begin
          want = units_due.pop_front();
          if (m_axis_tdata[15:0] !== want.code || m_axis_tdata[31:16] !== want.total ||
              m_axis_tuser !== want.run_last || m_axis_tlast !== want.string_end) begin
            if (fail_count < 10)
              $display("mismatch: expected code %h total %h rl %b se %b, got %h %h %b %b",
                       want.code, want.total, want.run_last, want.string_end,
                       m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser,
                       m_axis_tlast);
            fail_count++;
          end
        end
        rx_stall = pick_gap(rx_calm);
        if (hold_off || rx_stall > 0) begin
          m_axis_tready <= 1'b0;
          rx_wait       <= rx_stall;
        end
      end else if (!m_axis_tready) begin
        if (!hold_off) begin
          if (rx_wait > 0) rx_wait <= rx_wait - 1;
          else m_axis_tready <= 1'b1;
        end
      end else if (hold_off) begin
        m_axis_tready <= 1'b0;
      end
    end
  end

  // Long receiver hold-off mid-run so the block backs up onto its input
  initial begin
    @(posedge clk_i);
    while (bytes_taken < 40) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("utf8_to_utf16_transcoder regression: fail");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic fin);
    byte_req_t r;
    r.data = b;
    r.fin  = fin;
    r.gap  = pick_gap(tx_calm);
    byte_reqs.push_back(r);
  endtask

  // Wait until every request is through, then allow for a dropped tail
  task automatic wait_idle();
    @(posedge clk_i);
    while (byte_reqs.size() > 0 || s_axis_tvalid || units_due.size() > 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_term(input logic v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    term_on = v;
  endtask

  // Random strings: mostly well-formed characters, some noise and broken ones
  task automatic push_random_strings(input int n_items);
    logic [7:0] str[$];
    int added;
    int nchars;
    int len;
    int ncont;
    int r;
    added = 0;
    while (added < n_items) begin
      str.delete();
      nchars = $urandom_range(1, 6);
      for (int c = 0; c < nchars; c++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          len = $urandom_range(1, 4);
          case (len)
            1: str.push_back({1'b0, 7'($urandom)});
            2: str.push_back({3'b110, 5'($urandom)});
            3: str.push_back({4'b1110, 4'($urandom)});
            default: str.push_back({5'b11110, 3'($urandom)});
          endcase
          for (int k = 1; k < len; k++) str.push_back({2'b10, 6'($urandom)});
        end else if (r < 85) begin
          str.push_back(8'($urandom));
        end else begin
          // lead byte with too few continuations
          len = $urandom_range(2, 4);
          case (len)
            2: str.push_back({3'b110, 5'($urandom)});
            3: str.push_back({4'b1110, 4'($urandom)});
            default: str.push_back({5'b11110, 3'($urandom)});
          endcase
          ncont = $urandom_range(0, len - 2);
          for (int k = 0; k < ncont; k++)
            str.push_back({2'b10, 6'($urandom)});
        end
      end
      for (int k = 0; k < str.size(); k++) push_byte(str[k], k == str.size() - 1);
      added += str.size();
    end
  endtask

  // Main sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: no terminator
    write_term(1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hC2, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hEF, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hF0, 1'b0); push_byte(8'h90, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    // stray continuation as lead: small code point wraps in the pair
    push_byte(8'h80, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    // cut-off final sequence with nothing to emit
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b1);
    wait_idle();

    // Directed: terminator on, including three units from one byte
    write_term(1'b1);
    push_byte(8'h41, 1'b1);
    push_byte(8'hF0, 1'b0); push_byte(8'h9F, 1'b0); push_byte(8'h98, 1'b0);
    push_byte(8'h80, 1'b1);
    wait_idle();

    // Random phase with a random flag setting
    write_term(1'($urandom));
    push_random_strings(35);
    wait_idle();

    // Random phase without terminator
    write_term(1'b0);
    push_random_strings(35);
    wait_idle();
    repeat (10) @(posedge clk_i);

    if (fail_count == 0 && units_due.size() == 0) begin
      $display("utf8_to_utf16_transcoder regression: pass");
    end else begin
      $display("utf8_to_utf16_transcoder regression: fail");
    end
    $finish;
  end

endmodule

// ===== utf8_to_utf16_transcoder.f =====
design/u2u_pkg.sv
design/u2u_decode.sv
design/u2u_emit.sv
design/utf8_to_utf16_transcoder.sv
bench/testbench.sv
